### rtl/pbrt_pkg.sv
package pbrt_pkg;

	localparam int FUNC_W  = 2;
	localparam int FIRST_W = 16;
	localparam int COUNT_W = 17;
	localparam int WORD_W  = 64;
	localparam int BIT_W   = 6;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_SET   = 2'd1,
		FUNC_TEST  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// bits lo..hi inclusive
	function automatic logic [WORD_W-1:0] span_mask(logic [BIT_W-1:0] lo, logic [BIT_W-1:0] hi);
		logic [WORD_W-1:0] up;
		logic [WORD_W-1:0] down;
		up   = {WORD_W{1'b1}} << lo;
		down = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi);
		return up & down;
	endfunction

endpackage

### rtl/pbrt_if.sv
interface pbrt_req_if import pbrt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [FIRST_W-1:0] first_page;
	logic [COUNT_W-1:0] page_count;

	modport source(output valid, output func, output first_page, output page_count,
		input ready);
	modport sink(input valid, input func, input first_page, input page_count,
		output ready);
endinterface

interface pbrt_rsp_if;
	logic valid;
	logic ready;
	logic any_unmarked;
	logic status;

	modport source(output valid, output any_unmarked, output status, input ready);
	modport sink(input valid, input any_unmarked, input status, output ready);
endinterface

### rtl/pbrt_ram.sv
module pbrt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/page_bitmap_range_tracker.sv
// Page mark bitmap: one mark bit per page, kept as 64-bit words in one
// simple dual-port RAM (page p is bit p%64 of word p/64).
//
// req channel: func (clear / set / test), first_page, page_count.
// rsp channel: any_unmarked (test only), status (1 = range past the map,
// request ignored). Exactly one response per request, in order.
//
// Each request walks its words through a read-modify-write loop: a read is
// issued each cycle and the previous word is written back the same cycle;
// then DRAIN follows, and FINISH loads the output register once it is free.
// Rejected, empty and unused-opcode requests go from IDLE straight to FINISH.
// One request is in flight at a time; req.ready is high only when idle.
//
// Reset: a clearing pass zeroes the RAM, one word per cycle, while req.ready
// is held low.
// A stalled response sits in the output register; the next request is still
// taken, and its result waits until that register frees up.
module page_bitmap_range_tracker import pbrt_pkg::*; #(
	parameter int PAGE_COUNT = 65536
) (
	input  logic      clk,
	input  logic      arst_n,
	pbrt_req_if.sink  req,
	pbrt_rsp_if.source rsp
);

	localparam int MARK_WORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
	localparam int AW  = (MARK_WORDS > 1) ? $clog2(MARK_WORDS) : 1;
	localparam int EW0 = $clog2(PAGE_COUNT + 1);
	localparam int EW  = (EW0 > COUNT_W + 1) ? EW0 : COUNT_W + 1;
	localparam logic [EW-1:0] PAGE_LIMIT = EW'(PAGE_COUNT);
	localparam logic [AW-1:0] LAST_WORD  = AW'(MARK_WORDS - 1);

	state_t state_q, state_d;

	// request decode
	logic [EW-1:0]       start_x, end_x, last_x;
	logic [EW-BIT_W-1:0] wf_full, wl_full;
	logic                range_bad, noop;
	func_t               func_in;

	// request context
	func_t             func_q;
	logic [BIT_W-1:0]  lo_q, hi_q;
	logic [AW-1:0]     wfirst_q, wlast_q, rd_ptr_q, init_ptr_q;
	logic              any_q, stat_q;

	// read-data stage
	logic              v_s1, first_s1, last_s1;
	logic [AW-1:0]     addr_s1;

	// output register
	logic              out_valid_q, out_any_q, out_stat_q, out_free;

	// memory side
	logic              rd_en, init_wr, finish_ld, mem_we, hit;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata, rdata, mask;
	logic [BIT_W-1:0]  lo_cur, hi_cur;

	assign start_x   = EW'(req.first_page);
	assign end_x     = start_x + EW'(req.page_count);
	assign last_x    = end_x - EW'(1);
	assign wf_full   = start_x[EW-1:BIT_W];
	assign wl_full   = last_x[EW-1:BIT_W];
	assign range_bad = end_x > PAGE_LIMIT;
	assign func_in   = func_t'(req.func);
	assign noop      = (req.page_count == '0) || (func_in == FUNC_NONE);
	assign out_free  = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (init_ptr_q == LAST_WORD) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) state_d = (range_bad || noop) ? ST_FINISH : ST_RUN;
			end
			ST_RUN: begin
				if (rd_ptr_q == wlast_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// state outputs
	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		init_wr   = 1'b0;
		finish_ld = 1'b0;
		case (state_q)
			ST_INIT:   init_wr   = 1'b1;
			ST_IDLE:   req.ready = 1'b1;
			ST_RUN:    rd_en     = 1'b1;
			ST_DRAIN:  rd_en     = 1'b0;
			ST_FINISH: finish_ld = out_free;
			default:   rd_en     = 1'b0;
		endcase
	end

	// modify: edge words are trimmed to the range
	assign lo_cur = first_s1 ? lo_q : '0;
	assign hi_cur = last_s1 ? hi_q : BIT_W'(WORD_W - 1);
	assign mask   = span_mask(lo_cur, hi_cur);
	assign hit    = (rdata & mask) != mask;

	// Write-back of word w coincides with the read of word w+1; one request
	// never revisits a word, and the next request reads only after the last
	// write has landed, so no forwarding is needed.
	always_comb begin
		if (init_wr) begin
			mem_we    = 1'b1;
			mem_waddr = init_ptr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = v_s1 && (func_q != FUNC_TEST);
			mem_waddr = addr_s1;
			mem_wdata = (func_q == FUNC_SET) ? (rdata | mask) : (rdata & ~mask);
		end
	end

	pbrt_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MARK_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (rd_en),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_ptr_q  <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= rd_en;
			if (init_wr) init_ptr_q <= init_ptr_q + AW'(1);
			if (finish_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			func_q   <= func_in;
			lo_q     <= start_x[BIT_W-1:0];
			hi_q     <= last_x[BIT_W-1:0];
			wfirst_q <= wf_full[AW-1:0];
			wlast_q  <= wl_full[AW-1:0];
			rd_ptr_q <= wf_full[AW-1:0];
			any_q    <= 1'b0;
			stat_q   <= range_bad;
		end else begin
			if (rd_en) rd_ptr_q <= rd_ptr_q + AW'(1);
			if (v_s1 && (func_q == FUNC_TEST) && hit) any_q <= 1'b1;
		end
		addr_s1  <= rd_ptr_q;
		first_s1 <= rd_ptr_q == wfirst_q;
		last_s1  <= rd_ptr_q == wlast_q;
		if (finish_ld) begin
			out_any_q  <= any_q;
			out_stat_q <= stat_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.any_unmarked = out_any_q;
	assign rsp.status       = out_stat_q;

endmodule

### rtl/pbrt_checker.sv
module pbrt_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_any_unmarked,
	input logic rsp_status
);

	logic [1:0] open_q;
	logic       req_acc, rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			open_q <= open_q + 2'd1;
		end else if (rsp_acc && !req_acc) begin
			open_q <= open_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_err_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> !rsp_any_unmarked)
		else $error("rejected request reports unmarked pages");

	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while one is in flight");

	a_rsp_owed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (open_q != 2'd0) && (open_q != 2'd3))
		else $error("response without matching request");

endmodule

bind page_bitmap_range_tracker pbrt_checker u_pbrt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_any_unmarked(rsp.any_unmarked),
	.rsp_status      (rsp.status)
);

### dv/pbrt_range_checker.sv
module pbrt_range_checker import pbrt_pkg::*; #(
	parameter int PAGE_COUNT = 65536
) (
	input  logic clk,
	input  logic arst_n,
	pbrt_req_if  req,
	pbrt_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MARK_WORDS = (PAGE_COUNT + 63) / 64;

	typedef struct packed {
		logic any_unmarked;
		logic status;
	} outcome_t;

	logic [WORD_W-1:0] mark_words [MARK_WORDS];
	outcome_t          outcome_q [$];

	// pages lo..hi of one word
	function automatic logic [WORD_W-1:0] page_span(int unsigned lo, int unsigned hi);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int unsigned b = lo; b <= hi; b++)
			m[b] = 1'b1;
		return m;
	endfunction

	// applies one request to the shadow bitmap, returns its outcome
	function automatic outcome_t apply_range(func_t f, logic [FIRST_W-1:0] first,
		logic [COUNT_W-1:0] count);
		outcome_t          o;
		int unsigned       start;
		int unsigned       stop;
		int unsigned       w_first;
		int unsigned       w_last;
		int unsigned       lo;
		int unsigned       hi;
		logic [WORD_W-1:0] m;
		o = '0;
		start = first;
		stop = start + count;
		if (stop > PAGE_COUNT) begin
			o.status = 1'b1;
		end else if (count != 0 && f != FUNC_NONE) begin
			w_first = start / 64;
			w_last = (stop - 1) / 64;
			for (int unsigned w = w_first; w <= w_last; w++) begin
				lo = (w == w_first) ? start % 64 : 0;
				hi = (w == w_last) ? (stop - 1) % 64 : 63;
				m = page_span(lo, hi);
				case (f)
					FUNC_CLEAR: mark_words[w] = mark_words[w] & ~m;
					FUNC_SET:   mark_words[w] = mark_words[w] | m;
					default: begin
						if ((mark_words[w] & m) != m)
							o.any_unmarked = 1'b1;
					end
				endcase
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			for (int w = 0; w < MARK_WORDS; w++)
				mark_words[w] = '0;
			outcome_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// response first: it always belongs to an older request
			if (rsp.valid && rsp.ready) begin
				got.any_unmarked = rsp.any_unmarked;
				got.status = rsp.status;
				if (outcome_q.size() == 0) begin
					$display("%0t: response with none outstanding: any_unmarked=%0b status=%0b",
						$time, got.any_unmarked, got.status);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status expected %0b actual %0b",
							$time, want.status, got.status);
						fail_count++;
					end
					if (got.any_unmarked !== want.any_unmarked) begin
						$display("%0t: any_unmarked expected %0b actual %0b",
							$time, want.any_unmarked, got.any_unmarked);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				outcome_q.push_back(apply_range(func_t'(req.func), req.first_page,
					req.page_count));
			pending = outcome_q.size();
		end
	end

endmodule

### dv/tb_page_bitmap_range_tracker.sv
module tb_page_bitmap_range_tracker;
	import pbrt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE_COUNT   = 65536;
	localparam int RANDOM_REQS  = 580;
	// worst case: every request a full-map walk plus both sides' longest gaps,
	// the reset clearing pass and the long receiver hold-off, then several
	// times over
	localparam int CYCLE_LIMIT  = 2_500_000;
	localparam int HOLD_AT      = 120;   // response index where the long stall starts
	// longer than two full-map walks, so the block backs up whatever is in flight
	localparam int HOLD_CYCLES  = 3000;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   send_burst = 0;   // requests left to send back to back

	pbrt_req_if req_bus ();
	pbrt_rsp_if rsp_bus ();

	page_bitmap_range_tracker #(.PAGE_COUNT(PAGE_COUNT)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	pbrt_range_checker #(.PAGE_COUNT(PAGE_COUNT)) mark_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_bus),
		.rsp        (rsp_bus),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one request after a random gap and hold it until accepted.
	// valid is only lowered when there is a gap, so back-to-back requests
	// keep it high across the edge.
	task automatic send_req(func_t f, logic [FIRST_W-1:0] first, logic [COUNT_W-1:0] count);
		int gap;
		if (send_burst > 0) begin
			gap = 0;
			send_burst--;
		end else begin
			gap = $urandom_range(0, 8);
			if ($urandom_range(0, 15) == 0)
				send_burst = $urandom_range(10, 30);
		end
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.func       <= f;
		req_bus.first_page <= first;
		req_bus.page_count <= count;
		do @(posedge clk); while (!req_bus.ready);
	endtask

	// Random request, mostly well-formed ranges packed into the low pages so
	// that sets, clears and tests overlap; a few full-size walks; some noise.
	task automatic send_random_req();
		int unsigned        pick;
		int unsigned        first;
		int unsigned        count;
		func_t              f;
		pick = $urandom_range(0, 15);
		f = (pick == 15) ? FUNC_NONE : func_t'(pick % 3);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			first = $urandom_range(0, 2047);
			count = $urandom_range(1, 200);
		end else if (pick < 70) begin
			first = $urandom_range(0, 65535);
			count = $urandom_range(0, 130);
		end else if (pick < 78) begin
			// near the top of the map, some run past it
			first = PAGE_COUNT - $urandom_range(1, 300);
			count = $urandom_range(0, 400);
		end else if (pick < 84) begin
			first = $urandom_range(0, 4095);
			count = $urandom_range(4096, PAGE_COUNT - first);
		end else if (pick < 92) begin
			// raw fields, mostly out of range
			first = $urandom & 16'hFFFF;
			count = $urandom & 17'h1FFFF;
		end else begin
			first = $urandom & 16'hFFFF;
			count = 0;
		end
		send_req(f, first[FIRST_W-1:0], count[COUNT_W-1:0]);
	endtask

	// response side: random ready gaps, one long hold-off to back the block up
	initial begin
		int n;
		int w;
		n = 0;
		rsp_bus.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (n == HOLD_AT)
				w = HOLD_CYCLES;
			else if ($urandom_range(0, 3) == 0)
				w = 0;
			else
				w = $urandom_range(0, 8);
			if (w > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_bus.valid && rsp_bus.ready));
			n++;
		end
	end

	initial begin
		arst_n             <= 1'b0;
		req_bus.valid      <= 1'b0;
		req_bus.func       <= FUNC_CLEAR;
		req_bus.first_page <= '0;
		req_bus.page_count <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: whole map, top and bottom pages, word edges
		send_req(FUNC_TEST,  16'd0,     17'd65536);   // fresh map, all unmarked
		send_req(FUNC_SET,   16'd0,     17'd65536);
		send_req(FUNC_TEST,  16'd0,     17'd65536);
		send_req(FUNC_CLEAR, 16'd65535, 17'd1);       // last page only
		send_req(FUNC_TEST,  16'd65472, 17'd64);      // last word
		send_req(FUNC_TEST,  16'd0,     17'd65535);
		send_req(FUNC_SET,   16'd65535, 17'd1);
		send_req(FUNC_CLEAR, 16'd5,     17'd3);       // inside one word
		send_req(FUNC_TEST,  16'd4,     17'd1);
		send_req(FUNC_TEST,  16'd5,     17'd1);
		send_req(FUNC_CLEAR, 16'd60,    17'd10);      // straddles a word boundary
		send_req(FUNC_TEST,  16'd70,    17'd1);
		send_req(FUNC_TEST,  16'd69,    17'd1);
		send_req(FUNC_TEST,  16'd128,   17'd64);      // one aligned word
		// past the end of the map: flagged, no change
		send_req(FUNC_CLEAR, 16'd65535, 17'd2);
		send_req(FUNC_CLEAR, 16'd1,     17'd65536);
		send_req(FUNC_SET,   16'd65535, 17'h1FFFF);
		send_req(FUNC_TEST,  16'd65472, 17'd64);
		// empty ranges
		send_req(FUNC_CLEAR, 16'd0,     17'd0);
		send_req(FUNC_TEST,  16'd65535, 17'd0);
		// unused opcode does nothing
		send_req(FUNC_NONE,  16'd0,     17'd65536);
		send_req(FUNC_TEST,  16'd0,     17'd65536);
		send_req(FUNC_CLEAR, 16'd0,     17'd65536);
		send_req(FUNC_SET,   16'd0,     17'd1);
		send_req(FUNC_TEST,  16'd0,     17'd1);

		repeat (RANDOM_REQS) send_random_req();
		req_bus.valid <= 1'b0;

		// let the checker log the last accepted request before polling it
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
